// File: rtl/nplo_pkg.sv
package nplo_pkg;

  // Table depth default and minimum points for a valid query
  localparam int unsigned MaxPointsDef = 1024;
  localparam int unsigned MinPoints    = 4;

  // CORDIC setup: 16 steps, start vector is the gain K in Q3.30
  localparam int unsigned CordicSteps = 16;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // Sine and cosine in Q1.16, wide enough for +/-1.0
  typedef struct packed {
    logic signed [17:0] sin;
    logic signed [17:0] cos;
  } trig_t;

  // Difference of the nearest point to the pose
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } delta_t;

  // atan(2^-i) with 2^32 units per full turn
  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0:    r = 32'd536870912;
      4'd1:    r = 32'd316933406;
      4'd2:    r = 32'd167458907;
      4'd3:    r = 32'd85004756;
      4'd4:    r = 32'd42667331;
      4'd5:    r = 32'd21354465;
      4'd6:    r = 32'd10679838;
      4'd7:    r = 32'd5340245;
      4'd8:    r = 32'd2670163;
      4'd9:    r = 32'd1335087;
      4'd10:   r = 32'd667544;
      4'd11:   r = 32'd333772;
      4'd12:   r = 32'd166886;
      4'd13:   r = 32'd83443;
      4'd14:   r = 32'd41722;
      4'd15:   r = 32'd20861;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/nearest_point_lateral_offset.sv
// On a write busy_o stays low, and a write gives no result.
// A query with point_count below four strobes its result in the next cycle.
// Else, with n = min(point_count, MAX_POINTS), the result comes as busy_o falls;
// the scan reads n points, one point per cycle, through a five-stage pipeline, and
// the 16-step CORDIC finishes last for short tables. Results strobe on res_valid_o.
// Reset clears control state and point_count; the point table is not cleared.
module nearest_point_lateral_offset #(
  parameter int unsigned MAX_POINTS = nplo_pkg::MaxPointsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic [9:0]         point_index_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [15:0] heading_i,
  input  logic               point_count_we_i,
  input  logic [10:0]        point_count_i,
  output logic               res_valid_o,
  output logic               ok_o,
  output logic signed [31:0] offset_o,
  output logic [9:0]         nearest_index_o
);
  import nplo_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned NW =
    ($clog2(MAX_POINTS + 1) > 11) ? $clog2(MAX_POINTS + 1) : 11;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  logic [1:0]   state_q, state_d;
  logic [10:0]  count_q;
  logic         sdone_q, cdone_q;
  logic         res_valid_q, ok_q;
  logic signed [31:0] offset_q;
  logic [9:0]   idx_q;
  logic signed [50:0] p1_q, p2_q;

  logic [NW-1:0] n_cur;
  logic          accept, wr_req, query, enough;
  logic          scan_done, cordic_done, scan_start;
  delta_t        best;
  logic [AW-1:0] near_idx;
  trig_t         trig;
  logic signed [51:0] acc, shifted;

  // point count in use, clamped to the table depth
  always_comb begin
    n_cur = NW'(count_q);
    if (NW'(count_q) > NW'(MAX_POINTS)) begin
      n_cur = NW'(MAX_POINTS);
    end
  end

  assign accept     = start_i && !busy_o;
  assign wr_req     = accept && (req_type_i == REQ_WRITE) &&
                      (32'(point_index_i) < 32'(MAX_POINTS));
  assign query      = accept && (req_type_i == REQ_QUERY);
  assign enough     = n_cur >= NW'(MinPoints);
  assign scan_start = query && enough;
  assign busy_o     = (state_q != ST_IDLE);

  nplo_scan #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW),
    .NW         (NW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_req),
    .wr_addr_i  (AW'(point_index_i)),
    .wr_x_i     (coord_x_i),
    .wr_y_i     (coord_y_i),
    .start_i    (scan_start),
    .px_i       (coord_x_i),
    .py_i       (coord_y_i),
    .n_i        (n_cur),
    .done_o     (scan_done),
    .best_o     (best),
    .near_idx_o (near_idx)
  );

  nplo_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .heading_i (heading_i),
    .done_o    (cordic_done),
    .trig_o    (trig)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (scan_start) state_d = ST_RUN;
      ST_RUN:  if ((sdone_q || scan_done) && (cdone_q || cordic_done)) state_d = ST_MUL;
      ST_MUL:  state_d = ST_FIN;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // offset = dy*cos - dx*sin, rounded from Q.16 to whole units, then saturated
  assign acc     = 52'(p1_q) - 52'(p2_q) + 52'sd32768;
  assign shifted = acc >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sdone_q     <= 1'b0;
      cdone_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (point_count_we_i) begin
        count_q <= point_count_i;
      end
      if (scan_start) begin
        sdone_q <= 1'b0;
        cdone_q <= 1'b0;
      end else begin
        if (scan_done)   sdone_q <= 1'b1;
        if (cordic_done) cdone_q <= 1'b1;
      end
      res_valid_q <= (query && !enough) || (state_q == ST_FIN);
    end
  end

  // product and result registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      p1_q <= best.dy * trig.cos;
      p2_q <= best.dx * trig.sin;
    end
    if (query && !enough) begin
      ok_q     <= 1'b0;
      offset_q <= '0;
      idx_q    <= '0;
    end else if (state_q == ST_FIN) begin
      ok_q  <= 1'b1;
      idx_q <= 10'(near_idx);
      if (shifted > 52'sd2147483647) begin
        offset_q <= 32'sh7fffffff;
      end else if (shifted < -52'sd2147483648) begin
        offset_q <= 32'sh80000000;
      end else begin
        offset_q <= shifted[31:0];
      end
    end
  end

  assign res_valid_o     = res_valid_q;
  assign ok_o            = ok_q;
  assign offset_o        = offset_q;
  assign nearest_index_o = idx_q;

  // a not-ok result carries zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !ok_o |-> offset_o == 32'sd0 && nearest_index_o == 10'd0)
    else $error("not-ok result with nonzero payload");

  // a query with enough points makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_start |=> busy_o)
    else $error("query with enough points did not start the scan");

  // the final step always produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |=> res_valid_o && ok_o)
    else $error("finished query gave no result");

  // scan completion only while a query runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> state_q == ST_RUN)
    else $error("scan finished outside a query");

endmodule

// File: rtl/nplo_cordic.sv
module nplo_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [15:0]  heading_i,
  output logic                done_o,
  output nplo_pkg::trig_t     trig_o
);
  import nplo_pkg::*;

  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [3:0]         step_q, step_d;
  logic               run_q, run_d, fin_q, fin_d, flip_q, flip_d, done_q, done_d;
  trig_t              trig_q, trig_d;

  logic signed [16:0] h_ext;
  logic signed [16:0] h_fold;
  logic signed [33:0] xs, ys, atan_s, x_rnd, y_rnd;

  always_comb begin
    // fold heading into [-pi/2, pi/2]
    h_ext  = 17'(heading_i);
    h_fold = h_ext;
    flip_d = flip_q;
    if (h_ext > 17'sd16384) begin
      h_fold = h_ext - 17'sd32768;
    end else if (h_ext < -17'sd16384) begin
      h_fold = h_ext + 17'sd32768;
    end

    xs     = x_q >>> step_q;
    ys     = y_q >>> step_q;
    atan_s = $signed({2'b00, atan_turn(step_q)});
    x_rnd  = (x_q + 34'sd8192) >>> 14;
    y_rnd  = (y_q + 34'sd8192) >>> 14;

    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    run_d  = run_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    trig_d = trig_q;

    if (start_i) begin
      x_d    = CordicGain;
      y_d    = '0;
      z_d    = 34'(h_fold) <<< 16;
      step_d = '0;
      run_d  = 1'b1;
      flip_d = (h_ext > 17'sd16384) || (h_ext < -17'sd16384);
    end else if (run_q) begin
      // one micro-rotation per cycle
      if (!z_q[33]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_s;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_s;
      end
      step_d = step_q + 4'd1;
      if (step_q == 4'(CordicSteps - 1)) begin
        run_d = 1'b0;
        fin_d = 1'b1;
      end
    end else if (fin_q) begin
      // round to Q1.16, undo the fold
      trig_d.cos = flip_q ? -x_rnd[17:0] : x_rnd[17:0];
      trig_d.sin = flip_q ? -y_rnd[17:0] : y_rnd[17:0];
      done_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      flip_q <= 1'b0;
    end else begin
      step_q <= step_d;
      run_q  <= run_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      flip_q <= flip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    trig_q <= trig_d;
  end

  assign done_o = done_q;
  assign trig_o = trig_q;

endmodule

// File: rtl/nplo_scan.sv
module nplo_scan #(
  parameter int unsigned MAX_POINTS = nplo_pkg::MaxPointsDef,
  parameter int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  parameter int unsigned NW = ($clog2(MAX_POINTS + 1) > 11) ? $clog2(MAX_POINTS + 1) : 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic signed [31:0]  wr_x_i,
  input  logic signed [31:0]  wr_y_i,
  input  logic                start_i,
  input  logic signed [31:0]  px_i,
  input  logic signed [31:0]  py_i,
  input  logic [NW-1:0]       n_i,
  output logic                done_o,
  output nplo_pkg::delta_t    best_o,
  output logic [AW-1:0]       near_idx_o
);
  import nplo_pkg::*;

  logic [63:0] mem [MAX_POINTS];

  // issue side
  logic              active_q;
  logic [NW-1:0]     cnt_q, last_q;
  logic signed [31:0] px_q, py_q;

  // pipeline registers
  logic [63:0]        rd_q;
  logic               v1_q, v2_q, v3_q, v4_q;
  logic               f1_q, f2_q, f3_q, f4_q;
  logic               l1_q, l2_q, l3_q, l4_q;
  logic [AW-1:0]      i1_q, i2_q, i3_q, i4_q;
  delta_t             d2_q, d3_q, d4_q;
  logic signed [65:0] sqx3_q, sqy3_q;
  logic [65:0]        dist4_q;

  // best so far
  logic [65:0]        best_dist_q;
  delta_t             best_q;
  logic [AW-1:0]      near_idx_q;
  logic               done_q;

  logic [NW-1:0]      last_idx;
  assign last_idx = n_i - NW'(1);

  // table write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_x_i, wr_y_i};
    end
    rd_q <= mem[cnt_q[AW-1:0]];
  end

  // address counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      cnt_q    <= '0;
    end else if (active_q) begin
      cnt_q <= cnt_q + NW'(1);
      if (cnt_q == last_q) begin
        active_q <= 1'b0;
      end
    end
  end

  // valid and done flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= active_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      done_q <= v4_q && l4_q;
    end
  end

  // datapath: diff, square, sum, compare
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      px_q   <= px_i;
      py_q   <= py_i;
      last_q <= last_idx;
    end
    f1_q <= (cnt_q == '0);
    l1_q <= (cnt_q == last_q);
    i1_q <= cnt_q[AW-1:0];

    d2_q.dx <= 33'($signed(rd_q[63:32])) - 33'(px_q);
    d2_q.dy <= 33'($signed(rd_q[31:0])) - 33'(py_q);
    f2_q <= f1_q;
    l2_q <= l1_q;
    i2_q <= i1_q;

    sqx3_q <= d2_q.dx * d2_q.dx;
    sqy3_q <= d2_q.dy * d2_q.dy;
    d3_q   <= d2_q;
    f3_q   <= f2_q;
    l3_q   <= l2_q;
    i3_q   <= i2_q;

    dist4_q <= $unsigned(sqx3_q) + $unsigned(sqy3_q);
    d4_q    <= d3_q;
    f4_q    <= f3_q;
    l4_q    <= l3_q;
    i4_q    <= i3_q;

    // strict less keeps the lowest index on ties
    if (v4_q && (f4_q || (dist4_q < best_dist_q))) begin
      best_dist_q <= dist4_q;
      best_q      <= d4_q;
      near_idx_q  <= i4_q;
    end
  end

  assign done_o     = done_q;
  assign best_o     = best_q;
  assign near_idx_o = near_idx_q;

endmodule

// File: sim/nearest_point_lateral_offset_tb.sv
module nearest_point_lateral_offset_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPts    = nplo_pkg::MaxPointsDef;
  localparam int unsigned MinPts    = nplo_pkg::MinPoints;
  localparam int unsigned CfgSettle = 20;

  typedef enum logic {REQ_WRITE = 1'b0, REQ_QUERY = 1'b1} req_kind_e;

  typedef struct {
    req_kind_e         kind;
    logic [9:0]        idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] hdg;
  } request_t;

  typedef struct {
    logic              ok;
    logic signed [31:0] offset;
    logic [9:0]        nearest;
  } offset_res_t;

  // Keeps pending offset results in request order and counts mismatches
  class offset_scoreboard;
    offset_res_t pending[$];
    int unsigned errors;
    int unsigned matched;

    function void note_query(offset_res_t r);
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(offset_res_t got);
      offset_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result ok=%0d off=%0d idx=%0d", $realtime,
                   got.ok, got.offset, got.nearest);
        return;
      end
      want = pending.pop_front();
      if (got.ok !== want.ok || got.offset !== want.offset ||
          got.nearest !== want.nearest) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] mismatch: exp ok=%0d off=%0d idx=%0d, got ok=%0d off=%0d idx=%0d",
                   $realtime, want.ok, want.offset, want.nearest,
                   got.ok, got.offset, got.nearest);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               req_type_i = 1'b0;
  logic [9:0]         point_index_i = '0;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic signed [15:0] heading_i = '0;
  logic               point_count_we_i = 1'b0;
  logic [10:0]        point_count_i = '0;
  logic               res_valid_o;
  logic               ok_o;
  logic signed [31:0] offset_o;
  logic [9:0]         nearest_index_o;

  nearest_point_lateral_offset DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_type_i, .point_index_i,
    .coord_x_i, .coord_y_i, .heading_i, .point_count_we_i, .point_count_i,
    .res_valid_o, .ok_o, .offset_o, .nearest_index_o
  );

  // Local copy of the point table and register
  logic signed [31:0] path_x[MaxPts];
  logic signed [31:0] path_y[MaxPts];
  bit                 loaded[MaxPts];
  logic [10:0]        active_count = '0;

  offset_scoreboard sb = new();
  int unsigned idle_pct = 0;
  int unsigned n_writes = 0;
  int unsigned n_queries = 0;

  // Rotation CORDIC, heading folded into +/- pi/2, Q1.16 outputs
  function automatic void heading_trig(input logic signed [15:0] hdg,
                                       output longint s, output longint c);
    longint h, x, y, z, xs, ys;
    bit flip;
    h = hdg;
    flip = 0;
    if (h > 16384) begin
      h -= 32768;
      flip = 1;
    end else if (h < -16384) begin
      h += 32768;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    z = h * 65536;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(nplo_pkg::atan_turn(i[3:0]));
      end else begin
        x += ys; y -= xs; z += longint'(nplo_pkg::atan_turn(i[3:0]));
      end
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Nearest stored point and its offset along the left normal
  function automatic offset_res_t lateral_offset(request_t r);
    offset_res_t res;
    int unsigned n, best;
    logic [65:0] d2, best_d2, ax, ay;
    longint dx, dy, s, c, v;
    res = '{ok: 1'b0, offset: '0, nearest: '0};
    n = (active_count > MaxPts) ? MaxPts : active_count;
    if (n < MinPts) return res;
    best = 0;
    best_d2 = '0;
    for (int unsigned i = 0; i < n; i++) begin
      dx = longint'(path_x[i]) - longint'(r.x);
      dy = longint'(path_y[i]) - longint'(r.y);
      ax = (dx < 0) ? 66'(-dx) : 66'(dx);
      ay = (dy < 0) ? 66'(-dy) : 66'(dy);
      d2 = ax * ax + ay * ay;
      if (i == 0 || d2 < best_d2) begin
        best_d2 = d2;
        best = i;
      end
    end
    dx = longint'(path_x[best]) - longint'(r.x);
    dy = longint'(path_y[best]) - longint'(r.y);
    heading_trig(r.hdg, s, c);
    v = (dy * c - dx * s + 32768) >>> 16;
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    res.ok = 1'b1;
    res.offset = v[31:0];
    res.nearest = best[9:0];
    return res;
  endfunction

  // Clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results pending", sb.pending.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o)
      sb.check_result('{ok: ok_o, offset: offset_o, nearest: nearest_index_o});
  end

  // Drive one request at a falling edge and hold it until accepted
  task automatic send_req(request_t r);
    req_type_i    = r.kind;
    point_index_i = r.idx;
    coord_x_i     = r.x;
    coord_y_i     = r.y;
    heading_i     = r.hdg;
    start_i       = 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (r.kind == REQ_WRITE) begin
      path_x[r.idx] = r.x;
      path_y[r.idx] = r.y;
      loaded[r.idx] = 1;
      n_writes++;
    end else begin
      sb.note_query(lateral_offset(r));
      n_queries++;
    end
    @(negedge clk_i);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic write_point(int unsigned i, logic signed [31:0] x, logic signed [31:0] y);
    send_req('{kind: REQ_WRITE, idx: i[9:0], x: x, y: y, hdg: 16'($urandom)});
  endtask

  task automatic query(logic signed [31:0] x, logic signed [31:0] y, logic signed [15:0] h);
    send_req('{kind: REQ_QUERY, idx: 10'($urandom), x: x, y: y, hdg: h});
  endtask

  // Let the block drain, then change the register
  task automatic drain();
    start_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (CfgSettle) @(negedge clk_i);
  endtask

  task automatic set_count(int unsigned cnt);
    drain();
    point_count_i    = cnt[10:0];
    point_count_we_i = 1'b1;
    @(negedge clk_i);
    point_count_we_i = 1'b0;
    active_count     = cnt[10:0];
  endtask

  function automatic logic signed [31:0] rand_coord(logic signed [31:0] near);
    case ($urandom_range(3))
      0:       return 32'($urandom);
      1:       return near + 32'(signed'($urandom_range(0, 2 ** 21) - 2 ** 20));
      default: return near + 32'(signed'($urandom_range(0, 2 ** 12) - 2 ** 11));
    endcase
  endfunction

  // Fill entries below the count that were never loaded
  task automatic load_prefix(int unsigned cnt);
    int unsigned n;
    n = (cnt > MaxPts) ? MaxPts : cnt;
    for (int unsigned i = 0; i < n; i++)
      if (!loaded[i]) write_point(i, rand_coord('0), rand_coord('0));
  endtask

  task automatic random_phase(int unsigned cnt, int unsigned items);
    int unsigned n, k, j;
    logic signed [31:0] cx, cy;
    n = (cnt > MaxPts) ? MaxPts : cnt;
    set_count(cnt);
    load_prefix(cnt);
    for (int unsigned m = 0; m < items; m++) begin
      if ($urandom_range(99) < 35) begin
        k = (n > 0 && $urandom_range(3) != 0) ? $urandom_range(n - 1) : $urandom_range(MaxPts - 1);
        if (n > 1 && $urandom_range(4) == 0) begin
          // duplicate of another point gives a distance tie
          j = $urandom_range(n - 1);
          cx = path_x[j];
          cy = path_y[j];
          write_point(k, cx, cy);
        end else begin
          write_point(k, rand_coord(n > 0 ? path_x[0] : '0), rand_coord(n > 0 ? path_y[0] : '0));
        end
        if (!(k < n) && !loaded[k]) loaded[k] = 1;
      end else begin
        k = (n > 0) ? $urandom_range(n - 1) : 0;
        query(rand_coord(path_x[k]), rand_coord(path_y[k]), 16'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned counts[10] = '{5, 9, 17, 3, 33, 4, 64, 1, 12, 40};
    wait (rst_ni);
    @(negedge clk_i);

    // Directed: empty table after reset, then extremes and special cases
    query(32'sh7FFF_FFFF, -32'sh8000_0000, 16'sh7FFF);
    write_point(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    write_point(1, -32'sh8000_0000, -32'sh8000_0000);
    write_point(2, 32'sh0001_0000, 32'sh0000_0000);
    write_point(3, 32'sh0001_0000, 32'sh0000_0000);
    write_point(1023, 32'sh0000_0000, 32'sh0002_0000);
    query('0, '0, '0);
    set_count(0);
    query('0, '0, '0);
    set_count(3);
    query('0, '0, 16'sh4000);
    set_count(4);
    query('0, '0, '0);
    query('0, '0, 16'sh4000);
    query('0, '0, -16'sh4000);
    query('0, '0, 16'sh4001);
    query('0, '0, -16'sh4001);
    query('0, '0, -16'sh8000);
    query('0, '0, 16'sh7FFF);
    query(-32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh4000);
    query(32'sh7FFF_FFFF, -32'sh8000_0000, -16'sh4000);
    query(-32'sh8000_0000, -32'sh8000_0000, 16'sh2000);
    query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -16'sh6000);
    set_count(1024);
    drain();

    // Random phases under three idling regimes
    for (int unsigned p = 0; p < 10; p++) begin
      idle_pct = (p < 3) ? 30 : (p < 6) ? 58 : 0;
      random_phase(counts[p], 48);
    end

    // Minimum table once more with random headings
    idle_pct = 30;
    set_count(4);
    repeat (5) query(rand_coord(path_x[2]), rand_coord(path_y[2]), 16'($urandom));

    drain();
    repeat (CfgSettle) @(posedge clk_i);
    $display("covered %0d point writes and %0d queries with point counts up to 64,",
             n_writes, n_queries);
    $display("%0d results matched, %0d mismatches", sb.matched, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: nearest_point_lateral_offset.f
rtl/nplo_pkg.sv
rtl/nplo_cordic.sv
rtl/nplo_scan.sv
rtl/nearest_point_lateral_offset.sv
sim/nearest_point_lateral_offset_tb.sv
